### rtl/plin_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Shared types, codes and constants for the interpolator block.
// ----------------------------------------------------------------------------
`default_nettype none

package plin_pkg;

    // Data widths of the Q16.16 fields.
    localparam int DATA_WIDTH        = 32;
    localparam int VALUE_WIDTH       = 32;
    localparam int DEF_TABLE_DEPTH   = 256;
    localparam int QUEUE_DEPTH       = 4;
    localparam int FRAC_BITS         = 16;
    localparam logic [16:0] ONE_Q16  = 17'd65536;

    // Input function codes.
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_IN_RANGE = 2'd0;
    localparam logic [1:0] ST_BELOW    = 2'd1;
    localparam logic [1:0] ST_ABOVE    = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_FRAC  = 2'd1;
    localparam logic [1:0] REG_BELOW = 2'd2;
    localparam logic [1:0] REG_ABOVE = 2'd3;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_QUERY
    } t_op;

    // One queued operation: x carries point_x or query_x.
    typedef struct packed {
        t_op                     op;
        logic [DATA_WIDTH-1:0]   x;
        logic [DATA_WIDTH-1:0]   y;
    } t_entry;

    typedef struct packed {
        logic                    interp_mode;
        logic [16:0]             step_fraction;
        logic [DATA_WIDTH-1:0]   below_value;
        logic [DATA_WIDTH-1:0]   above_value;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BIS_RD,
        S_BIS_CMP,
        S_RD_I,
        S_RD_J,
        S_CAP_J,
        S_CHK,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_FIN,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

### rtl/plin_front.sv
// ----------------------------------------------------------------------------
// Interpolator front end
// Accepts input beats, decodes the function code and queues operations.
// ----------------------------------------------------------------------------
`default_nettype none

module plin_front
    import plin_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [1:0]             i_func,
    input  wire logic [DATA_WIDTH-1:0]  i_point_x,
    input  wire logic [DATA_WIDTH-1:0]  i_point_y,
    input  wire logic [DATA_WIDTH-1:0]  i_query_x,
    output logic                        o_q_valid,
    output t_entry                      o_q_entry,
    input  wire logic                   i_q_pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_entry            r_queue [QUEUE_DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [PW:0]       r_fill;
    logic              accept;
    logic              push;
    logic              pop;
    t_entry            entry;

    assign o_stall   = (r_fill == PW'(0) + (PW+1)'(QUEUE_DEPTH));
    assign accept    = i_valid && !o_stall;
    assign o_q_valid = (r_fill != '0);
    assign o_q_entry = r_queue[r_rd_ptr];
    assign pop       = i_q_pop && o_q_valid;

    // Decode the function code; the unused code is dropped here.
    always_comb begin
        entry.x  = i_point_x;
        entry.y  = i_point_y;
        entry.op = OP_CLEAR;
        push     = accept;
        case (i_func)
            FUNC_CLEAR:  entry.op = OP_CLEAR;
            FUNC_APPEND: entry.op = OP_APPEND;
            FUNC_QUERY: begin
                entry.op = OP_QUERY;
                entry.x  = i_query_x;
            end
            default:     push = 1'b0;
        endcase
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= entry;
        end
    end

    // Queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + (PW+1)'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - (PW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/plin_back.sv
// ----------------------------------------------------------------------------
// Interpolator execution unit
// Holds the breakpoint table, bisects, divides and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module plin_back
    import plin_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_valid,
    input  wire t_entry                 i_q_entry,
    output logic                        o_q_pop,
    input  wire t_cfg                   i_cfg,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [DATA_WIDTH-1:0]       o_value,
    output logic [1:0]                  o_status
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = DATA_WIDTH;

    // Table memories.
    logic [DW-1:0]   mem_x [TABLE_DEPTH];
    logic [DW-1:0]   mem_y [TABLE_DEPTH];
    logic [DW-1:0]   r_rd_x;
    logic [DW-1:0]   r_rd_y;
    logic [IW-1:0]   rd_addr;
    logic            wr_en;

    t_state          r_state;
    t_state          n_state;
    logic [CW-1:0]   r_count;
    logic [DW-1:0]   r_first_x;
    logic [DW-1:0]   r_last_x;
    logic [DW-1:0]   r_v;
    logic [IW-1:0]   r_i;
    logic [IW-1:0]   r_j;
    logic [DW-1:0]   r_xi;
    logic [DW-1:0]   r_yi;
    logic [DW-1:0]   r_xj;
    logic [DW-1:0]   r_yj;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_span;
    logic [15:0]     r_frac;
    logic [3:0]      r_div_cnt;
    logic signed [51:0] r_prod;
    logic signed [51:0] r_acc;
    logic [DW-1:0]   r_res_value;
    logic [1:0]      r_res_status;
    logic            r_out_valid;
    logic [DW-1:0]   r_out_value;
    logic [1:0]      r_out_status;

    logic [IW:0]     mid_sum;
    logic [IW-1:0]   mid;
    logic [IW-1:0]   bis_i_nxt;
    logic [IW-1:0]   bis_j_nxt;
    logic [IW-1:0]   last_idx;
    logic            q_lt_first;
    logic            q_gt_last;
    logic            app_ok;
    logic            out_free;
    logic            emit;
    logic [DW:0]     rem2;
    logic            rem_ge;
    logic [16:0]     f_eff;
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;
    logic signed [51:0] fin_sum;
    logic [DW-1:0]   fin_sat;

    // Saturate a 36-bit signed value to the signed VALUE_WIDTH range.
    function automatic logic [DW-1:0] sat36(input logic signed [35:0] v);
        logic signed [35:0] maxv;
        logic signed [35:0] minv;
        maxv = 36'sd0 + ((36'sd1 <<< (VALUE_WIDTH - 1)) - 36'sd1);
        minv = -maxv - 36'sd1;
        if (v > maxv) begin
            sat36 = maxv[DW-1:0];
        end else if (v < minv) begin
            sat36 = minv[DW-1:0];
        end else begin
            sat36 = v[DW-1:0];
        end
    endfunction

    // Bisection midpoint and interval update.
    assign mid_sum   = {1'b0, r_i} + {1'b0, r_j};
    assign mid       = mid_sum[IW:1];
    assign bis_i_nxt = ($signed(r_v) < $signed(r_rd_x)) ? r_i : mid;
    assign bis_j_nxt = ($signed(r_v) < $signed(r_rd_x)) ? mid : r_j;
    assign last_idx  = IW'(r_count - CW'(1));

    // Bound checks and append check.
    assign q_lt_first = $signed(i_q_entry.x) < $signed(r_first_x);
    assign q_gt_last  = $signed(i_q_entry.x) > $signed(r_last_x);
    assign app_ok     = (r_count < CW'(TABLE_DEPTH)) &&
                        ((r_count == '0) || ($signed(i_q_entry.x) > $signed(r_last_x)));

    // Restoring divider step.
    assign rem2   = {r_rem, 1'b0};
    assign rem_ge = rem2 >= {1'b0, r_span};

    // Shared multiplier.
    assign f_eff = (i_cfg.step_fraction > ONE_Q16) ? ONE_Q16 : i_cfg.step_fraction;
    always_comb begin
        mul_a = {r_yi[DW-1], r_yi};
        mul_b = $signed({1'b0, ONE_Q16 - f_eff});
        if (!i_cfg.interp_mode) begin
            mul_a = $signed({r_yj[DW-1], r_yj}) - $signed({r_yi[DW-1], r_yi});
            mul_b = $signed({2'b0, r_frac});
        end else if (r_state == S_MUL2) begin
            mul_a = {r_yj[DW-1], r_yj};
            mul_b = $signed({1'b0, f_eff});
        end
    end
    assign mul_p = mul_a * mul_b;

    // Final floor and saturation.
    assign fin_sum = r_acc + r_prod;
    assign fin_sat = sat36(fin_sum[51:16]);

    assign out_free = !r_out_valid || !i_stall;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && (i_q_entry.op == OP_QUERY)) begin
                    if ((r_count == '0) || q_lt_first || q_gt_last) begin
                        n_state = S_EMIT;
                    end else if (CW'(2) < r_count) begin
                        n_state = S_BIS_RD;
                    end else begin
                        n_state = S_RD_I;
                    end
                end
            end
            S_BIS_RD:  n_state = S_BIS_CMP;
            S_BIS_CMP: begin
                if ((IW+1)'(bis_i_nxt) + (IW+1)'(1) < (IW+1)'(bis_j_nxt)) begin
                    n_state = S_BIS_RD;
                end else begin
                    n_state = S_RD_I;
                end
            end
            S_RD_I:  n_state = S_RD_J;
            S_RD_J:  n_state = S_CAP_J;
            S_CAP_J: n_state = S_CHK;
            S_CHK: begin
                if ((r_v == r_xj) || (r_v == r_xi)) begin
                    n_state = S_EMIT;
                end else if (!i_cfg.interp_mode) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_MUL1;
                end
            end
            S_DIV: begin
                if (r_div_cnt == 4'd15) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: n_state = i_cfg.interp_mode ? S_MUL2 : S_FIN;
            S_MUL2: n_state = S_FIN;
            S_FIN:  n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_q_pop = 1'b0;
        wr_en   = 1'b0;
        emit    = 1'b0;
        rd_addr = r_i;
        case (r_state)
            S_IDLE: begin
                o_q_pop = i_q_valid;
                wr_en   = i_q_valid && (i_q_entry.op == OP_APPEND) && app_ok;
            end
            S_BIS_RD: rd_addr = mid;
            S_RD_I:   rd_addr = r_i;
            S_RD_J:   rd_addr = r_j;
            S_EMIT:   emit = out_free;
            default:  rd_addr = r_i;
        endcase
    end

    // Table memories: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_x[IW'(r_count)] <= i_q_entry.x;
            mem_y[IW'(r_count)] <= i_q_entry.y;
        end
        r_rd_x <= mem_x[rd_addr];
        r_rd_y <= mem_y[rd_addr];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_q_valid && i_q_entry.op == OP_CLEAR) begin
                r_count <= '0;
            end else if (wr_en) begin
                r_count <= r_count + CW'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_last_x <= i_q_entry.x;
            if (r_count == '0) begin
                r_first_x <= i_q_entry.x;
            end
        end
        if (emit) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
        case (r_state)
            S_IDLE: begin
                r_v          <= i_q_entry.x;
                r_i          <= '0;
                r_j          <= last_idx;
                r_res_status <= ST_IN_RANGE;
                if (r_count == '0) begin
                    r_res_value  <= '0;
                    r_res_status <= ST_EMPTY;
                end else if (q_lt_first) begin
                    r_res_value  <= sat36(36'(signed'(i_cfg.below_value)));
                    r_res_status <= ST_BELOW;
                end else if (q_gt_last) begin
                    r_res_value  <= sat36(36'(signed'(i_cfg.above_value)));
                    r_res_status <= ST_ABOVE;
                end
            end
            S_BIS_CMP: begin
                r_i <= bis_i_nxt;
                r_j <= bis_j_nxt;
            end
            S_RD_J: begin
                r_xi <= r_rd_x;
                r_yi <= r_rd_y;
            end
            S_CAP_J: begin
                r_xj <= r_rd_x;
                r_yj <= r_rd_y;
            end
            S_CHK: begin
                r_rem     <= r_v - r_xi;
                r_span    <= r_xj - r_xi;
                r_div_cnt <= '0;
                if (r_v == r_xj) begin
                    r_res_value <= sat36(36'(signed'(r_yj)));
                end else if (r_v == r_xi) begin
                    r_res_value <= sat36(36'(signed'(r_yi)));
                end
            end
            S_DIV: begin
                r_rem     <= rem_ge ? DW'(rem2 - {1'b0, r_span}) : rem2[DW-1:0];
                r_frac    <= {r_frac[14:0], rem_ge};
                r_div_cnt <= r_div_cnt + 4'd1;
            end
            S_MUL1: begin
                r_prod <= 52'(mul_p);
                r_acc  <= 52'(signed'(r_yi)) <<< FRAC_BITS;
            end
            S_MUL2: begin
                r_acc  <= r_prod;
                r_prod <= 52'(mul_p);
            end
            S_FIN: r_res_value <= fin_sat;
            default: r_res_value <= r_res_value;
        endcase
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;

`ifndef SYNTHESIS
    // The point count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("point count beyond table depth");

    // Bisection only runs on a non-empty interval.
    a_bis_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BIS_CMP) |-> (r_i < r_j))
        else $error("bisection interval collapsed");

    // A table read only starts on a non-empty table.
    a_bis_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_I) |-> (r_count != '0))
        else $error("table read on empty table");

    // A result is loaded only out of the emit state.
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("result raised outside emit");
`endif

endmodule

`default_nettype wire

### rtl/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator
// Breakpoint table with bisection lookup and linear or weighted-step output.
//
//   Channel   Direction  Handshake          Payload
//   input     in         i_valid/o_stall    i_func, i_point_x, i_point_y, i_query_x
//   output    out        o_valid/i_stall    o_value, o_status
//   config    in         APB psel/penable   paddr, pwdata, prdata
//
// A clear or append beat is handled in the idle state of the execution unit. An
// in-range query bisects the table on the single table read port, reads and checks
// the interval, runs the restoring divider in linear mode, then multiplies (twice
// in step mode), saturates and emits. Boundary and empty-table queries go straight
// from the idle state to the emit state.
// Reset is synchronous and clears the point count, queue and registers.
// A four-entry queue accepts input beats while the output stalls, until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_interpolator
    import plin_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [1:0]             i_func,
    input  wire logic [DATA_WIDTH-1:0]  i_point_x,
    input  wire logic [DATA_WIDTH-1:0]  i_point_y,
    input  wire logic [DATA_WIDTH-1:0]  i_query_x,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [DATA_WIDTH-1:0]       o_value,
    output logic [1:0]                  o_status,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [3:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    t_cfg     r_cfg;
    logic     q_valid;
    t_entry   q_entry;
    logic     q_pop;
    logic     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MODE:  r_cfg.interp_mode   <= pwdata[0];
                REG_FRAC:  r_cfg.step_fraction <= pwdata[16:0];
                REG_BELOW: r_cfg.below_value   <= pwdata;
                REG_ABOVE: r_cfg.above_value   <= pwdata;
                default:   r_cfg <= r_cfg;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[3:2])
            REG_MODE:  prdata = {31'd0, r_cfg.interp_mode};
            REG_FRAC:  prdata = {15'd0, r_cfg.step_fraction};
            REG_BELOW: prdata = r_cfg.below_value;
            REG_ABOVE: prdata = r_cfg.above_value;
            default:   prdata = '0;
        endcase
    end

    plin_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_func    (i_func),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_query_x (i_query_x),
        .o_q_valid (q_valid),
        .o_q_entry (q_entry),
        .i_q_pop   (q_pop)
    );

    plin_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_q_pop   (q_pop),
        .i_cfg     (r_cfg),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_value   (o_value),
        .o_status  (o_status)
    );

endmodule

`default_nettype wire

### verif/tb_piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator testbench
// Drives clear, append and query beats with random gaps and output stalls,
// programs the registers over APB between phases, and checks every result
// against a directed value or a behavioral model of the table in this bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_piecewise_linear_interpolator;
    import plin_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         DEPTH       = DEF_TABLE_DEPTH;
    localparam int         RAND_ITEMS  = 1050;
    localparam int         IDLE_WAIT   = 80;
    localparam longint     XMIN        = -64'sd2147483648;
    localparam longint     XMAX        = 64'sd2147483647;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  status;
    } t_result;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] qx;
        bit          typed;
        logic [31:0] value;
        logic [1:0]  status;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_func = FUNC_CLEAR;
    logic [31:0] i_point_x = '0;
    logic [31:0] i_point_y = '0;
    logic [31:0] i_query_x = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_value;
    logic [1:0]  o_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    piecewise_linear_interpolator u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_func    (i_func),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_query_x (i_query_x),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_value   (o_value),
        .o_status  (o_status),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Shadow of the breakpoint table and the registers.
    logic signed [31:0] tab_x [DEPTH];
    logic signed [31:0] tab_y [DEPTH];
    int                 point_cnt;
    logic               cfg_mode;
    logic [16:0]        cfg_frac;
    logic signed [31:0] cfg_below;
    logic signed [31:0] cfg_above;

    t_result     pending_results[$];
    t_row        directed[$];
    int          mismatches;
    bit          gaps_quiet;
    bit          stalls_quiet;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("piecewise_linear_interpolator test failed");
        $finish;
    end

    function automatic logic [31:0] clamp32(input longint v);
        if (v > XMAX) return 32'h7fffffff;
        if (v < XMIN) return 32'h80000000;
        return v[31:0];
    endfunction

    // Expected result of a query against the shadow table.
    function automatic t_result lookup_value(input logic signed [31:0] qx);
        t_result r;
        longint  v, xi, xj, yi, yj, frac, f, p;
        int      lo, hi, mid;
        v = qx;
        if (point_cnt == 0) begin
            r.value = '0;
            r.status = ST_EMPTY;
            return r;
        end
        lo = 0;
        hi = point_cnt - 1;
        if (v < tab_x[0]) begin
            r.value = clamp32(cfg_below);
            r.status = ST_BELOW;
            return r;
        end
        if (v > tab_x[hi]) begin
            r.value = clamp32(cfg_above);
            r.status = ST_ABOVE;
            return r;
        end
        r.status = ST_IN_RANGE;
        while (lo + 1 < hi) begin
            mid = (lo + hi) / 2;
            if (v < tab_x[mid]) hi = mid;
            else lo = mid;
        end
        xi = tab_x[lo];
        xj = tab_x[hi];
        yi = tab_y[lo];
        yj = tab_y[hi];
        if (v == xj) begin
            r.value = clamp32(yj);
        end else if (v == xi) begin
            r.value = clamp32(yi);
        end else if (cfg_mode == 1'b0) begin
            frac = ((v - xi) <<< 16) / (xj - xi);
            r.value = clamp32(yi + (((yj - yi) * frac) >>> 16));
        end else begin
            f = (cfg_frac > ONE_Q16) ? longint'(ONE_Q16) : longint'(cfg_frac);
            p = yi * (65536 - f) + yj * f;
            r.value = clamp32(p >>> 16);
        end
        return r;
    endfunction

    // Applies one accepted beat to the shadow state; queries queue a result.
    task automatic apply_beat(input t_row row);
        t_result r;
        case (row.func)
            FUNC_CLEAR: begin
                point_cnt = 0;
            end
            FUNC_APPEND: begin
                if (point_cnt < DEPTH &&
                    (point_cnt == 0 || $signed(row.px) > tab_x[point_cnt-1])) begin
                    tab_x[point_cnt] = row.px;
                    tab_y[point_cnt] = row.py;
                    point_cnt++;
                end
            end
            FUNC_QUERY: begin
                r = lookup_value(row.qx);
                if (row.typed) begin
                    r.value = row.value;
                    r.status = row.status;
                end
                pending_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    // Sends one input beat, with an optional idle gap ahead of it.
    task automatic send_beat(input t_row row);
        bit taken;
        int gap;
        gap = 0;
        if (!gaps_quiet && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(1, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_func    <= row.func;
        i_point_x <= row.px;
        i_point_y <= row.py;
        i_query_x <= row.qx;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        apply_beat(row);
    endtask

    task automatic send_op(input logic [1:0] func, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] qx);
        t_row row;
        row = '{func, px, py, qx, 1'b0, 32'd0, 2'd0};
        send_beat(row);
    endtask

    // Waits until the block has drained, then lets its pipeline settle.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
        bit ready;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            ready = pready;
            @(posedge i_clk);
        end while (!ready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:  cfg_mode  = data[0];
            REG_FRAC:  cfg_frac  = data[16:0];
            REG_BELOW: cfg_below = data;
            REG_ABOVE: cfg_above = data;
            default: ;
        endcase
    endtask

    function automatic longint rand_between(input longint lo, input longint hi);
        longint unsigned span, raw;
        span = hi - lo + 1;
        raw  = {$urandom, $urandom};
        return lo + longint'(raw % span);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'(rand_between(-300000, 300000));
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(input logic [1:0] func, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] qx,
                           input bit typed, input logic [31:0] value,
                           input logic [1:0] status);
        directed.push_back('{func, px, py, qx, typed, value, status});
    endtask

    // Result checker: each output beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: value %h status %0d",
                             o_value, o_status);
            end else begin
                want = pending_results.pop_front();
                if (o_value !== want.value || o_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %h/%0d, got %h/%0d",
                                 want.value, want.status, o_value, o_status);
                end
            end
        end
    end

    // Output stall pattern: mostly short stalls, a few long ones.
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (stalls_quiet || $urandom_range(0, 2) != 0) begin
                i_stall <= 1'b0;
            end else begin
                n = ($urandom_range(0, 12) == 0) ? $urandom_range(15, 60)
                                                 : $urandom_range(1, 4);
                i_stall <= 1'b1;
                repeat (n - 1) @(posedge i_clk);
                @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        int          sent, n, k, pick;
        longint      base, step, x, lo, hi;
        logic [31:0] qx;

        mismatches   = 0;
        point_cnt    = 0;
        cfg_mode     = 1'b0;
        cfg_frac     = '0;
        cfg_below    = '0;
        cfg_above    = '0;
        gaps_quiet   = 1'b0;
        stalls_quiet = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: empty table, extremes, exact hits, ignored beats.
        add_row(FUNC_QUERY, 0, 0, 0, 1, 32'd0, ST_EMPTY);
        add_row(FUNC_UNUSED, 0, 0, 0, 0, 0, 0);
        add_row(FUNC_APPEND, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0);
        add_row(FUNC_APPEND, 32'h80000000, 32'h00000001, 0, 0, 0, 0);
        add_row(FUNC_APPEND, 32'h00000000, 32'h80000000, 0, 0, 0, 0);
        add_row(FUNC_APPEND, 32'h7fffffff, 32'h00012345, 0, 0, 0, 0);
        add_row(FUNC_QUERY, 0, 0, 32'h80000000, 1, 32'h7fffffff, ST_IN_RANGE);
        add_row(FUNC_QUERY, 0, 0, 32'h7fffffff, 1, 32'h00012345, ST_IN_RANGE);
        add_row(FUNC_QUERY, 0, 0, 32'h00000000, 1, 32'h80000000, ST_IN_RANGE);
        add_row(FUNC_QUERY, 0, 0, 32'hc0000000, 0, 0, 0);
        add_row(FUNC_QUERY, 0, 0, 32'd12345, 0, 0, 0);
        add_row(FUNC_QUERY, 0, 0, 32'h7ffffffe, 0, 0, 0);
        add_row(FUNC_CLEAR, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0);
        add_row(FUNC_QUERY, 0, 0, 32'd5, 1, 32'd0, ST_EMPTY);
        add_row(FUNC_APPEND, 32'd100, 32'd7, 0, 0, 0, 0);
        add_row(FUNC_QUERY, 0, 0, 32'd99, 1, 32'd0, ST_BELOW);
        add_row(FUNC_QUERY, 0, 0, 32'd101, 1, 32'd0, ST_ABOVE);
        add_row(FUNC_QUERY, 0, 0, 32'd100, 1, 32'd7, ST_IN_RANGE);
        add_row(FUNC_APPEND, 32'h00010000, 32'hfffffffb, 0, 0, 0, 0);
        add_row(FUNC_QUERY, 0, 0, 32'h00008000, 0, 0, 0);
        add_row(FUNC_UNUSED, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0);
        foreach (directed[r]) send_beat(directed[r]);

        // Random phases: an occasional register setting, a table, then queries.
        sent = 0;
        while (sent < RAND_ITEMS) begin
            if ($urandom_range(0, 2) == 0 || sent == 0) begin
                wait_drained();
                reg_write(REG_MODE, $urandom_range(0, 1));
                case ($urandom_range(0, 4))
                    0: reg_write(REG_FRAC, 32'd0);
                    1: reg_write(REG_FRAC, 32'd65536);
                    2: reg_write(REG_FRAC, 32'h1ffff);
                    default: reg_write(REG_FRAC, $urandom);
                endcase
                reg_write(REG_BELOW, rand_word());
                reg_write(REG_ABOVE, rand_word());
            end
            gaps_quiet   = ($urandom_range(0, 5) == 0);
            stalls_quiet = ($urandom_range(0, 5) == 0);

            if ($urandom_range(0, 5) != 0) begin
                send_op(FUNC_CLEAR, $urandom, $urandom, $urandom);
                sent++;
            end

            // Mostly ascending points; now and then enough to overflow the table.
            n = ($urandom_range(0, 30) == 0) ? DEPTH + $urandom_range(1, 4)
                                             : $urandom_range(1, 10);
            case ($urandom_range(0, 3))
                0: step = $urandom_range(1, 4);
                1: step = $urandom_range(1, 2000);
                2: step = $urandom_range(1, 655360);
                default: step = (longint'(1) <<< 32) / (n + 1);
            endcase
            base = XMIN + rand_between(0, (longint'(1) <<< 32) - 1 - n * step);
            x = base;
            for (int a = 0; a < n; a++) begin
                if ($urandom_range(0, 15) == 0)
                    send_op(FUNC_APPEND, 32'(x - $urandom_range(0, 3)), $urandom, 0);
                else
                    send_op(FUNC_APPEND, 32'(x), rand_word(), 0);
                x += rand_between(1, step);
                if (x > XMAX) x = XMAX;
                sent++;
            end

            // Queries, mostly inside the table, with some noise beats.
            n = $urandom_range(4, 20);
            for (int q = 0; q < n; q++) begin
                pick = $urandom_range(0, 19);
                qx = $urandom;
                if (point_cnt > 0) begin
                    k = $urandom_range(0, point_cnt - 1);
                    if (pick < 11 && k + 1 < point_cnt) begin
                        lo = tab_x[k];
                        hi = tab_x[k+1];
                        qx = 32'(rand_between(lo, hi));
                    end else if (pick < 14) begin
                        qx = tab_x[k];
                    end else if (pick < 16) begin
                        qx = 32'(longint'(tab_x[0]) - $urandom_range(0, 3));
                    end else if (pick < 18) begin
                        qx = 32'(longint'(tab_x[point_cnt-1]) + $urandom_range(0, 3));
                    end
                end
                if (pick == 19)
                    send_op(FUNC_UNUSED, $urandom, $urandom, $urandom);
                else
                    send_op(FUNC_QUERY, $urandom, $urandom, qx);
                sent++;
            end
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("piecewise_linear_interpolator test passed");
        end else begin
            $display("piecewise_linear_interpolator test failed");
        end
        $finish;
    end

endmodule
